// ===== hdl/assert_macros.svh =====
// assertion macros shared by the loader modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every edge outside reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== hdl/ihex_pkg.sv =====
// shared constants and types of the hex record loader
package ihex_pkg;

  localparam int AddrBits = 16;

  // address increment after each byte write
  localparam logic [AddrBits-1:0] AddrStep = AddrBits'(1);

  // action codes of the input transfer
  localparam logic [1:0] ActClear = 2'd0;
  localparam logic [1:0] ActChar  = 2'd1;
  localparam logic [1:0] ActEnd   = 2'd2;

  // characters and record types
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] KindData  = 8'h00;
  localparam logic [7:0] KindEnd   = 8'h01;

  // one result item
  typedef struct packed {
    logic                write_valid;
    logic [AddrBits-1:0] write_address;
    logic [7:0]          write_data;
    logic                finished;
    logic                wrong_type;
  } result_t;

endpackage

// ===== hdl/ihex_parser.sv =====
// record parser: state registers and per-character next-state logic
`include "assert_macros.svh"

module ihex_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [1:0]            action,
  input  logic [7:0]            char_in,
  output ihex_pkg::result_t     res
);

  typedef enum logic [3:0] {
    PH_COLON, PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA,
    PH_CHECK, PH_EOL, PH_SKIP, PH_DONE, PH_ERROR
  } phase_t;

  phase_t                        phase, phase_next;
  logic [1:0]                    digit_index, digit_index_next;
  logic [15:0]                   field_accum, field_accum_next;
  logic [7:0]                    bytes_left, bytes_left_next;
  logic [ihex_pkg::AddrBits-1:0] load_address, load_address_next;
  logic [7:0]                    record_kind, record_kind_next;
  logic                          done_flag, done_flag_next;
  logic                          error_flag, error_flag_next;

  logic [3:0]  digit_val;
  logic [15:0] accum_shift;
  logic [1:0]  idx_inc;
  logic        pair_full;
  logic [7:0]  bytes_dec;

  // ascii hex digit to value, anything else reads as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
    return d[3:0];
  endfunction

  // digit shift shared by all field phases
  assign digit_val   = hex_value(char_in);
  assign accum_shift = {field_accum[11:0], digit_val};
  assign idx_inc     = digit_index + 2'd1;
  assign pair_full   = (idx_inc == 2'd2);
  assign bytes_dec   = bytes_left - 8'd1;

  // next state and result for the item in transfer
  always_comb begin
    phase_next        = phase;
    digit_index_next  = digit_index;
    field_accum_next  = field_accum;
    bytes_left_next   = bytes_left;
    load_address_next = load_address;
    record_kind_next  = record_kind;
    done_flag_next    = done_flag;
    error_flag_next   = error_flag;
    res               = '0;
    unique case (action)
      ihex_pkg::ActClear: begin
        phase_next        = PH_COLON;
        digit_index_next  = '0;
        field_accum_next  = '0;
        bytes_left_next   = '0;
        load_address_next = '0;
        record_kind_next  = '0;
        done_flag_next    = 1'b0;
        error_flag_next   = 1'b0;
      end
      ihex_pkg::ActEnd: begin
        if (phase != PH_DONE && phase != PH_ERROR) begin
          error_flag_next = 1'b1;
          phase_next      = PH_ERROR;
        end
      end
      ihex_pkg::ActChar: begin
        unique case (phase)
          PH_COLON: begin
            if (char_in == ihex_pkg::CharColon) begin
              phase_next       = PH_COUNT;
              digit_index_next = '0;
              field_accum_next = '0;
            end else begin
              error_flag_next = 1'b1;
              phase_next      = PH_ERROR;
            end
          end
          PH_COUNT: begin
            field_accum_next = accum_shift;
            digit_index_next = idx_inc;
            if (pair_full) begin
              digit_index_next = '0;
              bytes_left_next  = accum_shift[7:0];
              field_accum_next = '0;
              phase_next       = PH_ADDR;
            end
          end
          PH_ADDR: begin
            field_accum_next = accum_shift;
            digit_index_next = idx_inc;
            if (digit_index == 2'd3) begin
              digit_index_next  = '0;
              load_address_next = accum_shift[ihex_pkg::AddrBits-1:0];
              field_accum_next  = '0;
              phase_next        = PH_TYPE;
            end
          end
          PH_TYPE: begin
            field_accum_next = accum_shift;
            digit_index_next = idx_inc;
            if (pair_full) begin
              digit_index_next = '0;
              record_kind_next = accum_shift[7:0];
              field_accum_next = '0;
              if (accum_shift[7:0] == ihex_pkg::KindEnd) begin
                done_flag_next = 1'b1;
                phase_next     = PH_DONE;
              end else if (bytes_left == 8'd0) begin
                phase_next = PH_CHECK;
              end else begin
                phase_next = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            field_accum_next = accum_shift;
            digit_index_next = idx_inc;
            if (pair_full) begin
              digit_index_next = '0;
              if (record_kind == ihex_pkg::KindData) begin
                res.write_valid   = 1'b1;
                res.write_address = load_address;
                res.write_data    = accum_shift[7:0];
                load_address_next = load_address + ihex_pkg::AddrStep;
              end
              field_accum_next = '0;
              bytes_left_next  = bytes_dec;
              if (bytes_dec == 8'd0) phase_next = PH_CHECK;
            end
          end
          PH_CHECK: begin
            field_accum_next = accum_shift;
            digit_index_next = idx_inc;
            if (pair_full) begin
              digit_index_next = '0;
              field_accum_next = '0;
              phase_next       = PH_EOL;
            end
          end
          PH_EOL: begin
            phase_next = (char_in == ihex_pkg::CharCr) ? PH_SKIP : PH_COLON;
          end
          PH_SKIP: begin
            phase_next = PH_COLON;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.finished   = done_flag_next;
    res.wrong_type = error_flag_next;
  end

  // parser state, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_COLON;
      digit_index  <= '0;
      field_accum  <= '0;
      bytes_left   <= '0;
      load_address <= '0;
      record_kind  <= '0;
      done_flag    <= 1'b0;
      error_flag   <= 1'b0;
    end else if (push) begin
      phase        <= phase_next;
      digit_index  <= digit_index_next;
      field_accum  <= field_accum_next;
      bytes_left   <= bytes_left_next;
      load_address <= load_address_next;
      record_kind  <= record_kind_next;
      done_flag    <= done_flag_next;
      error_flag   <= error_flag_next;
    end
  end

  // a load ends either finished or in error, never both
  `ASSERT_CLK(a_done_err_excl, !(done_flag && error_flag))
  // byte writes only come from the data phase
  `ASSERT_CLK(a_write_in_data, res.write_valid |-> (phase == PH_DATA && action == ihex_pkg::ActChar))
  // a stopped load keeps its flag until a clear
  `ASSERT_CLK(a_err_sticky, (push && error_flag && action != ihex_pkg::ActClear) |=> error_flag)

endmodule

// ===== hdl/ihex_out.sv =====
// output register with one skid entry
`include "assert_macros.svh"

module ihex_out (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ihex_pkg::result_t     res,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ihex_pkg::result_t     out_data
);

  logic              skid_valid;
  ihex_pkg::result_t skid_data;
  logic              main_free;

  assign main_free = !out_valid || out_ready;
  assign in_ready  = !skid_valid;

  // valid bits of the two entries
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload of the two entries
  always_ff @(posedge clk) begin
    if (main_free) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (push) begin
      skid_data <= res;
    end
  end

  // skid entry only fills behind a held main entry
  `ASSERT_CLK(a_skid_behind_main, skid_valid |-> out_valid)
  // a transfer into a stalled output lands in the skid entry
  `ASSERT_CLK(a_stall_to_skid, (push && out_valid && !out_ready) |=> skid_valid)
  // the skid entry drains as soon as the main entry moves
  `ASSERT_CLK(a_skid_drain, (skid_valid && out_ready) |=> !skid_valid)

endmodule

// ===== hdl/intel_hex_record_loader.sv =====
// top level of the hex record loader: parser and output register
//
//  channel  signals                                     dir
//  in       in_valid in_ready action char_in            sink
//  out      out_valid out_ready write_valid             source
//           write_address write_data finished wrong_type
//
//  one character per clock while in_ready is high: the parser result of each
//  transfer is registered in the output entry, or in the skid entry if stalled.
//  the output register has one skid entry; in_ready drops only while it is
//  full, after out_ready was low with a result waiting.
//  rst clears the parser to wait for a colon and empties both entries.

module intel_hex_record_loader (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [7:0]                    char_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          write_valid,
  output logic [ihex_pkg::AddrBits-1:0] write_address,
  output logic [7:0]                    write_data,
  output logic                          finished,
  output logic                          wrong_type
);

  logic              push;
  ihex_pkg::result_t res;
  ihex_pkg::result_t out_data;

  assign push = in_valid && in_ready;

  ihex_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .action  (action),
    .char_in (char_in),
    .res     (res)
  );

  ihex_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res       (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // result fields to ports
  assign write_valid   = out_data.write_valid;
  assign write_address = out_data.write_address;
  assign write_data    = out_data.write_data;
  assign finished      = out_data.finished;
  assign wrong_type    = out_data.wrong_type;

endmodule
